### src/oaat_pkg.sv
// Shared types, widths and op codes for the one-at-a-time hash bucket block.
// No dependencies; imported by every module of the block.
`default_nettype none

package oaat_pkg;

  localparam int BYTE_W    = 8;
  localparam int HASH_W    = 32;
  localparam int BKT_W     = 24;
  localparam int SHAMT_W   = 4;
  localparam int ALU_OP_W  = 2;

  localparam logic [BKT_W-1:0] TABLE_SIZE_RST = BKT_W'(1024);

  // Shared mixing unit operations
  localparam logic [ALU_OP_W-1:0] ALU_ADD_BYTE = 2'd0;  // a + byte
  localparam logic [ALU_OP_W-1:0] ALU_ADD_SHL  = 2'd1;  // a + (a << sh)
  localparam logic [ALU_OP_W-1:0] ALU_XOR_SHR  = 2'd2;  // a ^ (a >> sh)

  // Control word for the mixing unit
  typedef struct packed {
    logic [ALU_OP_W-1:0] op;
    logic [SHAMT_W-1:0]  shamt;
  } alu_ctl_t;

  // Status of the modulo unit
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

### src/one_at_a_time_hash_bucket.sv
// Top level: one-at-a-time hash over a byte stream, with bucket index output.
// Depends on oaat_pkg, oaat_mix_alu and oaat_mod_unit.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | in_key_byte, in_has_byte, in_is_last
//   out     | output    | out_valid / out_ready| out_full_hash, out_bucket_index
//   cfg     | input     | cfg_valid / cfg_ready| cfg_table_size
//
// A byte transaction runs the add-byte, add-shift and xor-shift steps on the
// shared mixing unit; a closing transaction adds 3 finalization steps, the 32
// steps of the bit-serial modulo unit and a wait to see its done flag, and the
// load of the output register; with no byte, the byte steps are skipped.
// in_ready is high only while the sequencer is idle. A waiting result does not
// block new bytes; only the next load waits for the output register to drain.
// Synchronous active-low reset clears the running hash and sets 1024 buckets.
`default_nettype none

module one_at_a_time_hash_bucket (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [oaat_pkg::BYTE_W-1:0]  in_key_byte,
  input  logic                         in_has_byte,
  input  logic                         in_is_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [oaat_pkg::HASH_W-1:0]  out_full_hash,
  output logic [oaat_pkg::BKT_W-1:0]   out_bucket_index,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [oaat_pkg::BKT_W-1:0]   cfg_table_size
);
  import oaat_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADD10 = 3'd1;
  localparam logic [2:0] S_XOR6  = 3'd2;
  localparam logic [2:0] S_FIN3  = 3'd3;
  localparam logic [2:0] S_FIN11 = 3'd4;
  localparam logic [2:0] S_FIN15 = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic              last_r, last_nxt;
  logic [HASH_W-1:0] fin_r;
  logic [BKT_W-1:0]  table_size_r;
  logic              out_valid_r;
  logic [HASH_W-1:0] out_hash_r;
  logic [BKT_W-1:0]  out_bkt_r;

  alu_ctl_t          alu_ctl;
  logic [HASH_W-1:0] alu_res;
  logic              div_start;
  div_stat_t         div_stat;
  logic [BKT_W-1:0]  div_rem;
  logic              in_acc;
  logic              out_load;

  assign in_acc    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // Mixing unit control per step
  always_comb begin
    alu_ctl.op    = ALU_ADD_BYTE;
    alu_ctl.shamt = '0;
    case (state_r)
      S_ADD10: begin alu_ctl.op = ALU_ADD_SHL; alu_ctl.shamt = SHAMT_W'(10); end
      S_XOR6:  begin alu_ctl.op = ALU_XOR_SHR; alu_ctl.shamt = SHAMT_W'(6);  end
      S_FIN3:  begin alu_ctl.op = ALU_ADD_SHL; alu_ctl.shamt = SHAMT_W'(3);  end
      S_FIN11: begin alu_ctl.op = ALU_XOR_SHR; alu_ctl.shamt = SHAMT_W'(11); end
      S_FIN15: begin alu_ctl.op = ALU_ADD_SHL; alu_ctl.shamt = SHAMT_W'(15); end
      default: begin alu_ctl.op = ALU_ADD_BYTE; alu_ctl.shamt = '0; end
    endcase
  end

  oaat_mix_alu u_alu (
    .ctl (alu_ctl),
    .a   (hash_r),
    .b   (in_key_byte),
    .res (alu_res)
  );

  oaat_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (alu_res),
    .divisor   (table_size_r),
    .stat      (div_stat),
    .remainder (div_rem)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    hash_nxt  = hash_r;
    last_nxt  = last_r;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          last_nxt = in_is_last;
          if (in_has_byte) begin
            hash_nxt  = alu_res;
            state_nxt = S_ADD10;
          end else if (in_is_last) begin
            state_nxt = S_FIN3;
          end
        end
      end
      S_ADD10: begin
        hash_nxt  = alu_res;
        state_nxt = S_XOR6;
      end
      S_XOR6: begin
        hash_nxt  = alu_res;
        state_nxt = last_r ? S_FIN3 : S_IDLE;
      end
      S_FIN3: begin
        hash_nxt  = alu_res;
        state_nxt = S_FIN11;
      end
      S_FIN11: begin
        hash_nxt  = alu_res;
        state_nxt = S_FIN15;
      end
      S_FIN15: begin
        // final hash goes to fin_r and the divider; running value clears
        hash_nxt  = '0;
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      hash_r       <= '0;
      last_r       <= 1'b0;
      table_size_r <= TABLE_SIZE_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hash_r  <= hash_nxt;
      last_r  <= last_nxt;
      if (cfg_valid && cfg_ready) begin
        table_size_r <= cfg_table_size;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (div_start) begin
      fin_r <= alu_res;
    end
    if (out_load) begin
      out_hash_r <= fin_r;
      out_bkt_r  <= (table_size_r == '0) ? '0 : div_rem;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_full_hash    = out_hash_r;
  assign out_bucket_index = out_bkt_r;

endmodule

`default_nettype wire

### src/oaat_mix_alu.sv
// Shared shift/add/xor unit used for every mixing and finalization step.
// Depends on oaat_pkg.
`default_nettype none

module oaat_mix_alu (
  input  oaat_pkg::alu_ctl_t           ctl,
  input  logic [oaat_pkg::HASH_W-1:0]  a,
  input  logic [oaat_pkg::BYTE_W-1:0]  b,
  output logic [oaat_pkg::HASH_W-1:0]  res
);
  import oaat_pkg::*;

  // One operation per cycle, selected by the sequencer
  always_comb begin
    case (ctl.op)
      ALU_ADD_BYTE: res = a + HASH_W'(b);
      ALU_ADD_SHL:  res = a + (a << ctl.shamt);
      ALU_XOR_SHR:  res = a ^ (a >> ctl.shamt);
      default:      res = a;
    endcase
  end

endmodule

`default_nettype wire

### src/oaat_mod_unit.sv
// Restoring modulo unit: one quotient bit per cycle while busy.
// Depends on oaat_pkg.
`default_nettype none

module oaat_mod_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [oaat_pkg::HASH_W-1:0]  dividend,
  input  logic [oaat_pkg::BKT_W-1:0]   divisor,
  output oaat_pkg::div_stat_t          stat,
  output logic [oaat_pkg::BKT_W-1:0]   remainder
);
  import oaat_pkg::*;

  localparam int CNT_W = $clog2(HASH_W);

  logic [HASH_W-1:0] q_r;
  logic [BKT_W-1:0]  d_r;
  logic [BKT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [BKT_W:0]    trial;
  logic [BKT_W:0]    diff;
  logic [BKT_W-1:0]  rem_nxt;

  // Shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_r, q_r[HASH_W-1]};
    diff    = trial - {1'b0, d_r};
    rem_nxt = (trial >= {1'b0, d_r}) ? diff[BKT_W-1:0] : trial[BKT_W-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(HASH_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      d_r   <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[HASH_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

### src/oaat_checker.sv
// Port-level checks for one_at_a_time_hash_bucket, attached by bind.
// Depends on oaat_pkg and the top-level port list.
`default_nettype none

module oaat_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_has_byte,
  input logic                         in_is_last,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [oaat_pkg::HASH_W-1:0]  out_full_hash,
  input logic [oaat_pkg::BKT_W-1:0]   out_bucket_index
);
  import oaat_pkg::*;

  // Reset empties the output register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_full_hash)
      && $stable(out_bucket_index))
    else $error("stalled result changed");

  // Mixing a byte keeps the block busy for the following cycle
  a_byte_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_has_byte |=> !in_ready)
    else $error("ready during byte mixing");

  // A closing transaction cannot produce its result on the next edge
  a_no_fast_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_is_last |=> !$rose(out_valid))
    else $error("result appeared too early");

  // A zero hash always lands in bucket zero
  a_zero_bucket: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_full_hash == '0) |-> (out_bucket_index == '0))
    else $error("zero hash with nonzero bucket");

endmodule

bind one_at_a_time_hash_bucket oaat_checker u_oaat_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_has_byte      (in_has_byte),
  .in_is_last       (in_is_last),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_full_hash    (out_full_hash),
  .out_bucket_index (out_bucket_index)
);

`default_nettype wire

### verif/tb_one_at_a_time_hash_bucket.sv
// Self-checking testbench for one_at_a_time_hash_bucket: streams key bytes, predicts
// the finalized hash and its bucket for each closed key, checks both result fields.
// Depends on oaat_pkg and the one_at_a_time_hash_bucket RTL.
module tb_one_at_a_time_hash_bucket;
  timeunit 1ns;
  timeprecision 1ps;

  import oaat_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] key_byte;
    logic              has_byte;
    logic              is_last;
  } key_item_t;

  typedef struct packed {
    logic [HASH_W-1:0] full_hash;
    logic [BKT_W-1:0]  bucket_index;
  } bucket_result_t;

  // DUT connections; the inputs are driven to known values from time 0
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_key_byte = '0;
  logic              in_has_byte = 1'b0;
  logic              in_is_last = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [HASH_W-1:0] out_full_hash;
  logic [BKT_W-1:0]  out_bucket_index;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [BKT_W-1:0]  cfg_table_size = '0;

  // Stimulus and scoreboard state
  key_item_t      pending_items[$];
  bucket_result_t expected_buckets[$];
  key_item_t      next_item;
  bucket_result_t want;
  int             in_issue_cnt = 0;
  int             in_accept_cnt = 0;
  int             in_gap = 0;
  int             ready_stall = 0;
  int             mismatch_count = 0;
  bit             idling_on = 1'b1;

  // Shadow of the block's running hash and its one configuration register
  logic [HASH_W-1:0] shadow_hash = '0;
  logic [BKT_W-1:0]  shadow_table_size = TABLE_SIZE_RST;

  one_at_a_time_hash_bucket i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_key_byte      (in_key_byte),
    .in_has_byte      (in_has_byte),
    .in_is_last       (in_is_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_full_hash    (out_full_hash),
    .out_bucket_index (out_bucket_index),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_table_size   (cfg_table_size)
  );

  always #5 clk = ~clk;

  // Per-byte mixing step of the one-at-a-time hash
  function automatic logic [HASH_W-1:0] mix_key_byte(logic [HASH_W-1:0] h,
                                                     logic [BYTE_W-1:0] b);
    h = h + {{(HASH_W-BYTE_W){1'b0}}, b};
    h = h + (h << 10);
    h = h ^ (h >> 6);
    return h;
  endfunction

  // Avalanche applied when a key closes
  function automatic logic [HASH_W-1:0] finalize_hash(logic [HASH_W-1:0] h);
    h = h + (h << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    return h;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones; none when idling is off
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idling_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Input driver: holds each transaction until accepted, then idles or sends the next
  always @(negedge clk) begin
    if (in_valid && in_accept_cnt != in_issue_cnt) begin
      // still waiting for acceptance
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap   <= in_gap - 1;
    end else if (pending_items.size() > 0) begin
      next_item    = pending_items.pop_front();
      in_key_byte  <= next_item.key_byte;
      in_has_byte  <= next_item.has_byte;
      in_is_last   <= next_item.is_last;
      in_valid     <= 1'b1;
      in_issue_cnt = in_issue_cnt + 1;
      in_gap       <= pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result backpressure
  always @(negedge clk) begin
    if (ready_stall > 0) begin
      out_ready   <= 1'b0;
      ready_stall <= ready_stall - 1;
    end else begin
      out_ready   <= 1'b1;
      ready_stall <= pick_gap();
    end
  end

  // Monitor: check results, then predict from accepted input transactions
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_buckets.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual hash %h bucket %h",
                   $time, out_full_hash, out_bucket_index);
          mismatch_count++;
        end else begin
          want = expected_buckets.pop_front();
          if (out_full_hash !== want.full_hash) begin
            $display("%0t: full_hash mismatch, expected %h, actual %h",
                     $time, want.full_hash, out_full_hash);
            mismatch_count++;
          end
          if (out_bucket_index !== want.bucket_index) begin
            $display("%0t: bucket_index mismatch, expected %h, actual %h",
                     $time, want.bucket_index, out_bucket_index);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        in_accept_cnt <= in_accept_cnt + 1;
        if (in_has_byte)
          shadow_hash = mix_key_byte(shadow_hash, in_key_byte);
        if (in_is_last) begin
          want.full_hash    = finalize_hash(shadow_hash);
          want.bucket_index = (shadow_table_size == '0) ? '0 :
              BKT_W'(want.full_hash % {{(HASH_W-BKT_W){1'b0}}, shadow_table_size});
          expected_buckets.push_back(want);
          shadow_hash = '0;
        end
      end
    end
  end

  task automatic push_item(logic [BYTE_W-1:0] b, logic has, logic last);
    key_item_t it;
    it.key_byte = b;
    it.has_byte = has;
    it.is_last  = last;
    pending_items.push_back(it);
  endtask

  // Random keys, mostly well formed, with idle and stray transactions mixed in
  task automatic queue_random_keys(int n_items);
    int  produced;
    int  len;
    int  r;
    bit  close_apart;
    produced = 0;
    while (produced < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // stray transaction with all fields random
        push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        produced++;
      end else begin
        len = (r < 13) ? 0 : (r < 88) ? $urandom_range(1, 8) : $urandom_range(9, 40);
        close_apart = (len == 0) || ($urandom_range(0, 3) == 0);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 19) == 0)
            push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
          push_item(8'($urandom_range(0, 255)), 1'b1, (k == len - 1) && !close_apart);
          produced++;
        end
        if (close_apart) begin
          push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
          produced++;
        end
      end
    end
  endtask

  // Wait until every transaction is taken and every result has come back
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_accept_cnt != in_issue_cnt ||
           expected_buckets.size() != 0);
    // non-closing transactions may still be in flight; let the pipeline settle
    repeat (60) @(posedge clk);
  endtask

  task automatic write_table_size(logic [BKT_W-1:0] size);
    @(negedge clk);
    cfg_table_size <= size;
    cfg_valid      <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    shadow_table_size = size;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Main sequence
  initial begin
    logic [BKT_W-1:0] sizes[7];
    sizes = '{BKT_W'(1), {BKT_W{1'b1}}, '0, BKT_W'(7), BKT_W'(65536),
              BKT_W'($urandom_range(2, 300)), BKT_W'($urandom_range(1, 24'hFFFFFF))};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed keys at the reset table size
    push_item(8'h00, 1'b0, 1'b1);                           // empty key
    push_item(8'hA5, 1'b0, 1'b0);                           // idle transaction
    push_item(8'h5A, 1'b0, 1'b1);                           // empty key again
    push_item(8'h00, 1'b1, 1'b1);
    push_item(8'hFF, 1'b1, 1'b1);
    push_item(8'h61, 1'b1, 1'b0);                           // "abc"
    push_item(8'h62, 1'b1, 1'b0);
    push_item(8'h63, 1'b1, 1'b1);
    repeat (4) push_item(8'hFF, 1'b1, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);                           // close without a byte
    push_item(8'h01, 1'b1, 1'b0);
    push_item(8'h80, 1'b0, 1'b0);                           // idle inside a key
    push_item(8'h7F, 1'b1, 1'b1);
    push_item(8'h55, 1'b1, 1'b0);
    push_item(8'hAA, 1'b1, 1'b1);
    wait_drained();

    // Random keys across table sizes, including the extremes and zero
    foreach (sizes[i]) begin
      write_table_size(sizes[i]);
      idling_on = (i != 1) && (i != 4);
      queue_random_keys(120);
      wait_drained();
    end

    if (mismatch_count == 0)
      $display("tb_one_at_a_time_hash_bucket: clean");
    else
      $display("tb_one_at_a_time_hash_bucket: errors");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb_one_at_a_time_hash_bucket: errors");
    $finish;
  end

endmodule

### files.f
src/oaat_pkg.sv
src/oaat_mix_alu.sv
src/oaat_mod_unit.sv
src/one_at_a_time_hash_bucket.sv
src/oaat_checker.sv
verif/tb_one_at_a_time_hash_bucket.sv
